>>> rtl/core/btg_pkg.sv
// Shared types, constants and clamp helpers for the burst traffic generator.
package btg_pkg;

  // Field widths
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned GAP_W      = 32;
  localparam int unsigned CD_W       = 33;
  localparam int unsigned ERR_W      = 3;
  localparam int unsigned PEND_OUT_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Default parameter values
  localparam int unsigned PENDING_LIMIT_DEF = 1000;
  localparam int unsigned FIFO_DEPTH_DEF    = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE       = 3'd0,
    CFG_START_OFFSET = 3'd1,
    CFG_PERIOD_MIN   = 3'd2,
    CFG_PERIOD_MAX   = 3'd3,
    CFG_SIZE_MIN     = 3'd4,
    CFG_SIZE_MAX     = 3'd5,
    CFG_GAP_MIN      = 3'd6,
    CFG_GAP_MAX      = 3'd7
  } btg_cfg_idx_e;

  // Error codes, lowest nonzero wins
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 3'd0,
    ERR_PENDING = 3'd1,
    ERR_PERIOD  = 3'd2,
    ERR_EMPTY   = 3'd3,
    ERR_GAP     = 3'd4
  } btg_err_e;

  // Configuration register set
  typedef struct packed {
    logic                enable;
    logic [PERIOD_W-1:0] start_offset;
    logic [PERIOD_W-1:0] period_min;
    logic [PERIOD_W-1:0] period_max;
    logic [SIZE_W-1:0]   size_min;
    logic [SIZE_W-1:0]   size_max;
    logic [GAP_W-1:0]    gap_min;
    logic [GAP_W-1:0]    gap_max;
  } btg_cfg_t;

  // Classified tick as it travels from front to back
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [CD_W-1:0]     first_cd;
    logic [SIZE_W-1:0]   size;
    logic [GAP_W-1:0]    gap;
  } btg_item_t;

  // Below min gives min, else above max gives max
  function automatic logic [31:0] clamp32(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [15:0] clamp16(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    logic [15:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/core/btg_ifs.sv
// Valid/ready channel interfaces for tick input and result output.
interface btg_in_if;
  logic                          valid;
  logic                          ready;
  logic [btg_pkg::PERIOD_W-1:0]  period_sample;
  logic [btg_pkg::SIZE_W-1:0]    size_sample;
  logic [btg_pkg::GAP_W-1:0]     gap_sample;

  modport source (output valid, output period_sample, output size_sample,
                  output gap_sample, input ready);
  modport sink   (input valid, input period_sample, input size_sample,
                  input gap_sample, output ready);
endinterface

interface btg_out_if;
  logic                           valid;
  logic                           ready;
  logic                           packet_out;
  logic [btg_pkg::ERR_W-1:0]      error_code;
  logic [btg_pkg::PEND_OUT_W-1:0] pending_out;

  modport source (output valid, output packet_out, output error_code,
                  output pending_out, input ready);
  modport sink   (input valid, input packet_out, input error_code,
                  input pending_out, output ready);
endinterface

>>> rtl/core/btg_front.sv
// Front end: accepts ticks, clamps the samples and precomputes the first countdown.
module btg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  btg_in_if.sink            in_i,
  input  btg_pkg::btg_cfg_t cfg_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output btg_pkg::btg_item_t push_item_o
);
  import btg_pkg::*;

  logic      f_valid_q, f_valid_d;
  btg_item_t f_item_q, f_item_d;
  logic      in_fire;

  // Accept whenever the stage is empty or drains this cycle
  assign in_i.ready = !f_valid_q || push_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  // Clamp samples and form period plus start offset
  always_comb begin
    f_item_d.period   = clamp32(in_i.period_sample, cfg_i.period_min, cfg_i.period_max);
    f_item_d.first_cd = {1'b0, f_item_d.period} + {1'b0, cfg_i.start_offset};
    f_item_d.size     = clamp16(in_i.size_sample, cfg_i.size_min, cfg_i.size_max);
    f_item_d.gap      = clamp32(in_i.gap_sample, cfg_i.gap_min, cfg_i.gap_max);
  end

  always_comb begin
    f_valid_d = f_valid_q;
    if (in_fire) f_valid_d = 1'b1;
    else if (push_ready_i) f_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  // Hold the classified transaction until the queue takes it
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      f_item_q <= f_item_d;
    end
  end

  assign push_valid_o = f_valid_q;
  assign push_item_o  = f_item_q;

endmodule

>>> rtl/core/btg_fifo.sv
// Short queue decoupling the front end from the tick engine.
module btg_fifo #(
  parameter int unsigned DEPTH = btg_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  btg_pkg::btg_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output btg_pkg::btg_item_t pop_item_o
);
  import btg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  btg_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers with explicit wrap
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Fill level never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue fill level above depth");

endmodule

>>> rtl/core/btg_back.sv
// Tick engine: burst scheduling, pending count, packet emitter and result register.
module btg_back #(
  parameter int unsigned PENDING_LIMIT = btg_pkg::PENDING_LIMIT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  btg_pkg::btg_cfg_t  cfg_i,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  btg_pkg::btg_item_t pop_item_i,
  btg_out_if.source          out_o
);
  import btg_pkg::*;

  localparam int unsigned CNT_W = $clog2(PENDING_LIMIT + 2);
  localparam logic [CNT_W-1:0] PEND_LIM = CNT_W'(PENDING_LIMIT);
  localparam logic [CNT_W-1:0] PEND_SAT = CNT_W'(PENDING_LIMIT + 1);

  // Generator state
  logic              started_q, started_d;
  logic [CD_W-1:0]   bcd_q, bcd_d;
  logic [GAP_W-1:0]  gcd_q, gcd_d;
  logic              gap_act_q, gap_act_d;
  logic [CNT_W-1:0]  pend_q, pend_d;
  logic [SIZE_W-1:0] rem_q, rem_d;

  // Result register
  logic              o_valid_q, o_valid_d;
  logic              o_pkt_q;
  btg_err_e          o_err_q;
  logic [CNT_W-1:0]  o_pend_q;

  logic              pop, run;
  logic              arrive, gap_hold;
  logic [CNT_W-1:0]  pend_a, pend_b;
  logic [SIZE_W-1:0] rem_b;
  logic              pkt;
  logic              e_pend, e_period, e_empty, e_gap;
  btg_err_e          err;

  assign pop_ready_o = !o_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;
  assign run         = pop && cfg_i.enable;

  // Advance the schedule and the emitter by one tick
  always_comb begin
    started_d = started_q;
    bcd_d     = bcd_q;
    gcd_d     = gcd_q;
    gap_act_d = gap_act_q;
    pend_d    = pend_q;
    rem_d     = rem_q;
    pkt       = 1'b0;
    e_pend    = 1'b0;
    e_period  = 1'b0;
    e_empty   = 1'b0;
    e_gap     = 1'b0;
    arrive    = (bcd_q[CD_W-1:1] == '0);
    gap_hold  = gap_act_q && (gcd_q > 32'd1);
    pend_a    = pend_q;
    pend_b    = pend_q;
    rem_b     = rem_q;
    if (run) begin
      if (!started_q) begin
        started_d = 1'b1;
        e_period  = (pop_item_i.period == '0);
        bcd_d     = pop_item_i.first_cd;
      end else begin
        // Burst arrival, count saturates one above the limit
        if (arrive) begin
          if (pend_q >= PEND_SAT) pend_a = PEND_SAT;
          else pend_a = pend_q + 1'b1;
          e_pend   = (pend_q >= PEND_LIM);
          e_period = (pop_item_i.period == '0);
          bcd_d    = {1'b0, pop_item_i.period};
        end else begin
          bcd_d = bcd_q - 1'b1;
        end
        pend_b = pend_a;
        // Emitter: wait out the gap, else take a burst and send a packet
        if (gap_hold) begin
          gcd_d = gcd_q - 1'b1;
        end else begin
          gap_act_d = 1'b0;
          if ((rem_q == '0) && (pend_a != '0)) begin
            pend_b  = pend_a - 1'b1;
            rem_b   = pop_item_i.size;
            e_empty = (pop_item_i.size == '0);
          end
          if (rem_b != '0) begin
            pkt       = 1'b1;
            rem_b     = rem_b - 1'b1;
            e_gap     = (pop_item_i.gap == '0) && ((rem_b != '0) || (pend_b != '0));
            gap_act_d = 1'b1;
            gcd_d     = pop_item_i.gap;
          end
        end
        pend_d = pend_b;
        rem_d  = rem_b;
      end
    end
  end

  // Report the lowest raised code
  always_comb begin
    if (e_pend) err = ERR_PENDING;
    else if (e_period) err = ERR_PERIOD;
    else if (e_empty) err = ERR_EMPTY;
    else if (e_gap) err = ERR_GAP;
    else err = ERR_NONE;
  end

  always_comb begin
    o_valid_d = o_valid_q;
    if (pop) o_valid_d = 1'b1;
    else if (out_o.ready) o_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      bcd_q     <= '0;
      gcd_q     <= '0;
      gap_act_q <= 1'b0;
      pend_q    <= '0;
      rem_q     <= '0;
      o_valid_q <= 1'b0;
    end else begin
      started_q <= started_d;
      bcd_q     <= bcd_d;
      gcd_q     <= gcd_d;
      gap_act_q <= gap_act_d;
      pend_q    <= pend_d;
      rem_q     <= rem_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Load the result transaction
  always_ff @(posedge clk_i) begin
    if (pop) begin
      o_pkt_q  <= pkt;
      o_err_q  <= err;
      o_pend_q <= pend_d;
    end
  end

  assign out_o.valid       = o_valid_q;
  assign out_o.packet_out  = o_pkt_q;
  assign out_o.error_code  = o_err_q;
  assign out_o.pending_out = PEND_OUT_W'(o_pend_q);

  // Pending count stays within one above the limit
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_SAT)
    else $error("pending count beyond saturation");

  // A burst in flight only exists once the schedule has started
  a_rem_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rem_q != '0) || gap_act_q) |-> started_q)
    else $error("emitter busy before start");

  // Every emitted packet opens a gap
  a_pkt_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && pkt) |=> gap_act_q)
    else $error("packet emitted without gap");

endmodule

>>> rtl/core/burst_traffic_generator_unit.sv
// Top level of the burst traffic generator: configuration registers and unit wiring.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    period_sample[31:0] size_sample[15:0] gap_sample[31:0]
//  out_o    out  valid/ready    packet_out error_code[2:0] pending_out[9:0]
//  cfg      in   cfg_we_i       cfg_idx_i[2:0] cfg_data_i[31:0]
//
// One tick per clock is accepted while input ready is high; results are registered.
// The tick engine derives all next schedule state combinationally from each tick.
// Reset clears the registers to their defaults and the schedule to not started.
// A stalled output holds the result register; the queue and front stage absorb
// up to the queue depth plus one further transactions before input ready drops.
module burst_traffic_generator_unit #(
  parameter int unsigned PENDING_LIMIT = btg_pkg::PENDING_LIMIT_DEF,
  parameter int unsigned FIFO_DEPTH    = btg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  btg_in_if.sink                           in_i,
  btg_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [btg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [btg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import btg_pkg::*;

  btg_cfg_t  cfg_q;
  logic      push_valid, push_ready;
  btg_item_t push_item;
  logic      pop_valid, pop_ready;
  btg_item_t pop_item;

  // Configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable       <= 1'b0;
      cfg_q.start_offset <= '0;
      cfg_q.period_min   <= 32'd1;
      cfg_q.period_max   <= '1;
      cfg_q.size_min     <= 16'd1;
      cfg_q.size_max     <= '1;
      cfg_q.gap_min      <= 32'd1;
      cfg_q.gap_max      <= '1;
    end else if (cfg_we_i) begin
      unique case (btg_cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:       cfg_q.enable       <= cfg_data_i[0];
        CFG_START_OFFSET: cfg_q.start_offset <= cfg_data_i;
        CFG_PERIOD_MIN:   cfg_q.period_min   <= cfg_data_i;
        CFG_PERIOD_MAX:   cfg_q.period_max   <= cfg_data_i;
        CFG_SIZE_MIN:     cfg_q.size_min     <= cfg_data_i[SIZE_W-1:0];
        CFG_SIZE_MAX:     cfg_q.size_max     <= cfg_data_i[SIZE_W-1:0];
        CFG_GAP_MIN:      cfg_q.gap_min      <= cfg_data_i;
        CFG_GAP_MAX:      cfg_q.gap_max      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify incoming ticks
  btg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  // Decouple front and back
  btg_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Run the tick engine
  btg_back #(
    .PENDING_LIMIT (PENDING_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_o       (out_o)
  );

endmodule

>>> tb/burst_traffic_generator_unit_tb.sv
// Self-checking testbench for the burst traffic generator: stimulus, schedule model, checks.
module burst_traffic_generator_unit_tb;
  import btg_pkg::*;

  localparam int unsigned PEND_LIMIT = PENDING_LIMIT_DEF;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SIZE_W-1:0]   size;
    logic [GAP_W-1:0]    gap;
  } tick_t;

  typedef struct packed {
    logic                  pkt;
    btg_err_e              err;
    logic [PEND_OUT_W-1:0] pend;
  } tick_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  btg_in_if  tick_if ();
  btg_out_if res_if ();

  burst_traffic_generator_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock, period 8
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copy and schedule state of the generator model
  btg_cfg_t        regs;
  logic            sched_started;
  logic [CD_W-1:0] arrive_cd;
  logic [GAP_W-1:0] gap_cd;
  logic            gap_on;
  int unsigned     pend_cnt;
  logic [SIZE_W-1:0] left_cnt;

  tick_res_t   tick_results_q[$];
  int unsigned fail_cnt;
  int unsigned ticks_sent;
  int unsigned pkts_seen;
  int unsigned err_hits[5];
  bit          pace_tx;
  bit          pace_rx;
  int unsigned rx_hold;

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [31:0] fit(logic [31:0] v, logic [31:0] lo, logic [31:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Keep the first nonzero code, the lowest as callers raise codes in ascending order
  function automatic btg_err_e first_err(btg_err_e cur, btg_err_e code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  // Advance the schedule by one tick and return the result it gives
  function automatic tick_res_t advance_schedule(tick_t t);
    tick_res_t        r;
    logic [31:0]      per;
    logic [31:0]      gp;
    btg_err_e         e;
    r.pkt = 1'b0;
    e = ERR_NONE;
    if (regs.enable) begin
      per = fit(t.period, regs.period_min, regs.period_max);
      if (!sched_started) begin
        sched_started = 1'b1;
        if (per == 0) e = first_err(e, ERR_PERIOD);
        arrive_cd = {1'b0, per} + {1'b0, regs.start_offset};
      end else begin
        // burst arrival
        if (arrive_cd <= 1) begin
          if (pend_cnt >= PEND_LIMIT + 1) begin
            pend_cnt = PEND_LIMIT + 1;
            e = first_err(e, ERR_PENDING);
          end else begin
            pend_cnt++;
            if (pend_cnt > PEND_LIMIT) e = first_err(e, ERR_PENDING);
          end
          if (per == 0) e = first_err(e, ERR_PERIOD);
          arrive_cd = {1'b0, per};
        end else begin
          arrive_cd--;
        end
        // emitter
        if (gap_on && gap_cd > 1) begin
          gap_cd--;
        end else begin
          gap_on = 1'b0;
          if (left_cnt == 0 && pend_cnt > 0) begin
            pend_cnt--;
            left_cnt = 16'(fit({16'b0, t.size}, {16'b0, regs.size_min}, {16'b0, regs.size_max}));
            if (left_cnt == 0) e = first_err(e, ERR_EMPTY);
          end
          if (left_cnt != 0) begin
            gp = fit(t.gap, regs.gap_min, regs.gap_max);
            r.pkt = 1'b1;
            left_cnt--;
            if (gp == 0 && (left_cnt != 0 || pend_cnt > 0)) e = first_err(e, ERR_GAP);
            gap_on = 1'b1;
            gap_cd = gp;
          end
        end
      end
    end
    r.err = e;
    r.pend = pend_cnt[PEND_OUT_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want, input int unsigned got);
    $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
    fail_cnt++;
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_result();
    tick_res_t w;
    if (tick_results_q.size() == 0) begin
      flag_mismatch("result with no tick outstanding", 0, 1);
    end else begin
      w = tick_results_q.pop_front();
      if (res_if.packet_out !== w.pkt)
        flag_mismatch("packet_out", w.pkt, res_if.packet_out);
      if (res_if.error_code !== w.err)
        flag_mismatch("error_code", w.err, res_if.error_code);
      if (res_if.pending_out !== w.pend)
        flag_mismatch("pending_out", w.pend, res_if.pending_out);
      if (w.pkt) pkts_seen++;
      err_hits[w.err]++;
    end
  endtask

  // Result side: check on each transaction, stall ready at random
  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) check_result();
    if (rx_hold != 0) begin
      rx_hold--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      rx_hold = pace_rx ? pick_gap() : 0;
    end
  end

  // Send one tick, record its prediction once the transaction completes
  task automatic send_tick(input tick_t t);
    int unsigned idle;
    tick_if.valid         <= 1'b1;
    tick_if.period_sample <= t.period;
    tick_if.size_sample   <= t.size;
    tick_if.gap_sample    <= t.gap;
    do @(posedge clk_i); while (tick_if.ready !== 1'b1);
    tick_results_q.push_back(advance_schedule(t));
    ticks_sent++;
    idle = pace_tx ? pick_gap() : 0;
    if (idle != 0) begin
      tick_if.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic settle();
    tick_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [31:0] reg_value(btg_cfg_idx_e idx, btg_cfg_t c);
    case (idx)
      CFG_ENABLE:       return {31'b0, c.enable};
      CFG_START_OFFSET: return c.start_offset;
      CFG_PERIOD_MIN:   return c.period_min;
      CFG_PERIOD_MAX:   return c.period_max;
      CFG_SIZE_MIN:     return {16'b0, c.size_min};
      CFG_SIZE_MAX:     return {16'b0, c.size_max};
      CFG_GAP_MIN:      return c.gap_min;
      default:          return c.gap_max;
    endcase
  endfunction

  // Write all eight registers back to back; block must be idle
  task automatic load_regs(input btg_cfg_t c);
    btg_cfg_idx_e idx;
    settle();
    idx = idx.first();
    repeat (8) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= reg_value(idx, c);
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    regs = c;
  endtask

  function automatic btg_cfg_t make_regs(logic en, logic [31:0] off,
                                         logic [31:0] pmin, logic [31:0] pmax,
                                         logic [15:0] smin, logic [15:0] smax,
                                         logic [31:0] gmin, logic [31:0] gmax);
    btg_cfg_t c;
    c.enable = en;
    c.start_offset = off;
    c.period_min = pmin;
    c.period_max = pmax;
    c.size_min = smin;
    c.size_max = smax;
    c.gap_min = gmin;
    c.gap_max = gmax;
    return c;
  endfunction

  // Small values mostly; in wild mode one draw in four spans the whole field
  function automatic logic [31:0] draw(int unsigned lim, bit wild);
    if (wild && $urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, lim);
  endfunction

  task automatic run_phase(input btg_cfg_t c, input int unsigned n, input int unsigned per_lim,
                           input int unsigned size_lim, input int unsigned gap_lim,
                           input bit wild);
    tick_t t;
    load_regs(c);
    for (int unsigned i = 0; i < n; i++) begin
      // alternate paced and full-rate stretches
      if (i % 50 == 0) begin
        pace_tx = ($urandom_range(0, 9) < 7);
        pace_rx = ($urandom_range(0, 9) < 7);
      end
      t.period = draw(per_lim, wild);
      t.size   = SIZE_W'(draw(size_lim, wild));
      t.gap    = draw(gap_lim, wild);
      send_tick(t);
    end
  endtask

  // Disabled generator holds its state whatever the samples
  task automatic test_disabled_hold();
    send_tick('{32'h0, 16'h0, 32'h0});
    send_tick('{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF});
    send_tick('{32'hA5A5_5A5A, 16'h5A5A, 32'h5A5A_A5A5});
  endtask

  // Start offset, zero period, empty burst, zero gap and stacked errors
  task automatic test_special_cases();
    tick_t plan[14];
    plan = '{'{32'd0, 16'd0, 32'd0}, '{32'd1, 16'd0, 32'd0}, '{32'd0, 16'd0, 32'd0},
             '{32'd5, 16'd3, 32'd0}, '{32'd2, 16'hFFFF, 32'hFFFF_FFFF},
             '{32'hFFFF_FFFF, 16'd1, 32'd1}, '{32'd0, 16'd2, 32'd0}, '{32'd3, 16'd0, 32'd2},
             '{32'd1, 16'd4, 32'd1}, '{32'd0, 16'd0, 32'd0}, '{32'd2, 16'd1, 32'd0},
             '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}, '{32'd0, 16'd0, 32'd0},
             '{32'd1, 16'd2, 32'd0}};
    load_regs(make_regs(1'b1, 32'd2, 32'd0, 32'd3, 16'd0, 16'd4, 32'd0, 32'd2));
    foreach (plan[i]) send_tick(plan[i]);
  endtask

  // Minimum above maximum: below min gives min, everything else max
  task automatic test_inverted_clamps();
    tick_t plan[6];
    plan = '{'{32'd0, 16'd0, 32'd0}, '{32'd3, 16'd2, 32'd1}, '{32'd7, 16'd9, 32'd8},
             '{32'd5, 16'd4, 32'd3}, '{32'd2, 16'd1, 32'd0},
             '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF}};
    load_regs(make_regs(1'b1, 32'd0, 32'd5, 32'd2, 16'd4, 16'd1, 32'd3, 32'd0));
    foreach (plan[i]) send_tick(plan[i]);
  endtask

  // Random ticks across a series of register settings
  task automatic test_random_mix();
    run_phase(make_regs(1'b1, 32'd0, 32'd1, 32'd6, 16'd1, 16'd5, 32'd1, 32'd3),
              140, 8, 8, 8, 1'b1);
    run_phase(make_regs(1'b1, 32'd7, 32'd0, 32'd4, 16'd0, 16'd3, 32'd0, 32'd2),
              140, 6, 5, 4, 1'b1);
    run_phase(make_regs(1'b1, 32'd0, 32'd5, 32'd2, 16'd4, 16'd1, 32'd3, 32'd0),
              140, 8, 8, 6, 1'b1);
    run_phase(make_regs(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0),
              60, 8, 8, 8, 1'b1);
    run_phase(make_regs(1'b1, 32'd1, 32'd1, 32'd3, 16'd2, 16'd9, 32'd0, 32'd1),
              120, 5, 12, 3, 1'b1);
    // full clamp ranges: keep samples small so arrivals keep coming
    run_phase(make_regs(1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF,
                        32'd0, 32'hFFFF_FFFF), 150, 5, 6, 3, 1'b0);
  endtask

  // One arrival per tick with a busy emitter: pending count runs into its limit
  task automatic test_pending_saturation();
    run_phase(make_regs(1'b1, 32'd0, 32'd1, 32'd1, 16'hFFFF, 16'hFFFF, 32'd1500, 32'd1500),
              1100, 8, 8, 8, 1'b1);
  endtask

  initial begin
    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_ENABLE;
    cfg_data_i            <= '0;
    tick_if.valid         <= 1'b0;
    tick_if.period_sample <= '0;
    tick_if.size_sample   <= '0;
    tick_if.gap_sample    <= '0;
    regs = make_regs(1'b0, 32'd0, 32'd1, 32'hFFFF_FFFF, 16'd1, 16'hFFFF,
                     32'd1, 32'hFFFF_FFFF);
    sched_started = 1'b0;
    arrive_cd = '0;
    gap_cd = '0;
    gap_on = 1'b0;
    pend_cnt = 0;
    left_cnt = '0;
    fail_cnt = 0;
    ticks_sent = 0;
    pkts_seen = 0;
    foreach (err_hits[i]) err_hits[i] = 0;
    pace_tx = 1'b1;
    pace_rx = 1'b1;
    rx_hold = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled_hold();
    test_special_cases();
    test_inverted_clamps();
    test_random_mix();
    test_pending_saturation();

    settle();
    repeat (10) @(posedge clk_i);
    if (tick_results_q.size() != 0)
      flag_mismatch("ticks left without a result", 0, tick_results_q.size());
    $display("Ran %0d ticks over disabled, clamped, inverted, full-range and saturating settings",
             ticks_sent);
    $display("Saw %0d packets; errors pending/period/empty/gap: %0d/%0d/%0d/%0d",
             pkts_seen, err_hits[ERR_PENDING], err_hits[ERR_PERIOD], err_hits[ERR_EMPTY],
             err_hits[ERR_GAP]);
    if (fail_cnt == 0) begin
      $display("PASS burst_traffic_generator_unit");
    end else begin
      $display("FAIL burst_traffic_generator_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAIL burst_traffic_generator_unit");
    $finish;
  end

endmodule
